// ----- rtl/bol_pkg.sv -----
// Shared types, sizes and codes for the bounded ordered list.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package bol_pkg;

   localparam int CAPACITY      = 16;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int OP_W          = 3;
   localparam int INDEX_W       = 5;
   localparam int DATA_W        = 32;
   localparam int ENTRY_COUNT_W = 5;
   localparam int STATUS_W      = 2;
   localparam int CMP_W         = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
   localparam logic [OP_W-1:0] OP_PREPEND      = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DROP_LAST    = 3'd3;
   localparam logic [OP_W-1:0] OP_DROP_FIRST   = 3'd4;
   localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd5;
   localparam logic [OP_W-1:0] OP_GET_AT       = 3'd6;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [INDEX_W-1:0]        index;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_value;
      logic signed [DATA_W-1:0]  front_value;
      logic signed [DATA_W-1:0]  back_value;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   // Per-cell control, driven by the top level each cycle.
   typedef struct packed {
      logic load;      // take the new value
      logic shift_up;  // take the entry of the lower neighbor
      logic del_en;    // a deletion is in progress
      logic cmp_en;    // compare against the search value
      logic live;      // position is below the entry count
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/bol_cell.sv -----
// One position of the list: holds an entry, shifts toward either neighbor,
// and passes the first-match chain on. Depends on bol_pkg.
`default_nettype none

module bol_cell (
   input  wire                          clock,
   input  wire bol_pkg::cell_ctrl_type  ctrl,
   input  wire logic [bol_pkg::DATA_W-1:0] new_value,
   input  wire logic [bol_pkg::DATA_W-1:0] lower_entry,
   input  wire logic [bol_pkg::DATA_W-1:0] upper_entry,
   input  wire logic                    found_in,
   output logic [bol_pkg::DATA_W-1:0]   entry,
   output logic                         found_out
);
   import bol_pkg::*;

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic              match;

   assign match     = ctrl.cmp_en && ctrl.live && (entry_ff == new_value);
   // This cell and every one above it close the gap once a match is seen.
   assign found_out = found_in || match;

   always_comb begin
      if (ctrl.load) begin
         entry_in = new_value;
      end else if (ctrl.shift_up) begin
         entry_in = lower_entry;
      end else if (ctrl.del_en && found_out) begin
         entry_in = upper_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/bounded_ordered_list_unit.sv -----
// Top level of the bounded ordered list: command decode, entry count,
// the row of bol_cell positions and the result register. Depends on bol_pkg.
`default_nettype none

// Holds up to CAPACITY signed 32-bit entries in list order, one per cell of
// a shifting row. A command word is taken, the row inserts, deletes or shifts
// as the word is taken, and the result word (count, front, back, read value,
// status) is built from the updated row on the next cycle and held in an
// output register. No new word is taken during that update cycle; a new word
// is taken in the same cycle the previous result leaves. Remove-by-value
// finds the first match through a ripple chain across the cells. No clearing
// pass is needed after reset.
module bounded_ordered_list_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire bol_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output bol_pkg::rsp_type     rsp_data
);
   import bol_pkg::*;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [DATA_W-1:0]   rd_ff, rd_in;
   logic [STATUS_W-1:0] st_ff, st_in;

   logic [DATA_W-1:0]   entry [CAPACITY];
   logic                found [CAPACITY+1];
   cell_ctrl_type       ctrl  [CAPACITY];

   logic [CMP_W-1:0] count_cmp, idx_cmp, ins_pos, last_pos;
   logic [IDX_W-1:0] rd_pos, back_pos;
   logic accept, is_empty, is_full;
   logic op_ins, op_front, op_drop_last, op_drop_first, op_remove, op_get;
   logic ins_go, del_go, cmp_go, found_any;

   assign accept    = req_valid && req_ready;
   assign count_cmp = CMP_W'(count_ff);
   assign idx_cmp   = CMP_W'(req_data.index);
   assign last_pos  = count_cmp - CMP_W'(1);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));

   assign op_ins        = (req_data.operation == OP_APPEND) ||
                          (req_data.operation == OP_PREPEND) ||
                          (req_data.operation == OP_INSERT_AT);
   assign op_front      = (req_data.operation == OP_PREPEND) ||
                          ((req_data.operation == OP_INSERT_AT) && (idx_cmp == '0));
   assign op_drop_last  = (req_data.operation == OP_DROP_LAST);
   assign op_drop_first = (req_data.operation == OP_DROP_FIRST);
   assign op_remove     = (req_data.operation == OP_REMOVE_VALUE);
   assign op_get        = (req_data.operation == OP_GET_AT);

   assign ins_go = accept && op_ins && !is_full;
   assign del_go = accept && !is_empty && (op_drop_first || op_remove);
   assign cmp_go = accept && op_remove;

   always_comb begin
      if (op_front) begin
         ins_pos = '0;
      end else if ((req_data.operation == OP_APPEND) || (idx_cmp >= count_cmp)) begin
         ins_pos = count_cmp;
      end else begin
         ins_pos = idx_cmp;
      end
   end

   // Pop front seeds the chain so every live cell shifts down.
   assign found[0]  = op_drop_first;
   assign found_any = found[CAPACITY];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam logic [CMP_W-1:0] POS = CMP_W'(g);
      logic [DATA_W-1:0] lower, upper;

      assign ctrl[g].load     = ins_go && (ins_pos == POS);
      assign ctrl[g].shift_up = ins_go && (ins_pos < POS);
      assign ctrl[g].del_en   = del_go;
      assign ctrl[g].cmp_en   = cmp_go;
      assign ctrl[g].live     = (POS < count_cmp);

      if (g == 0) begin : g_first
         assign lower = '0;
      end else begin : g_mid_lo
         assign lower = entry[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper = entry[g];
      end else begin : g_mid_hi
         assign upper = entry[g+1];
      end

      bol_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl[g]),
         .new_value   (req_data.value),
         .lower_entry (lower),
         .upper_entry (upper),
         .found_in    (found[g]),
         .entry       (entry[g]),
         .found_out   (found[g+1])
      );
   end

   // Read past the end returns the last entry.
   always_comb begin
      if (idx_cmp < count_cmp) begin
         rd_pos = idx_cmp[IDX_W-1:0];
      end else begin
         rd_pos = last_pos[IDX_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      st_in    = st_ff;
      if (accept) begin
         rd_in = '0;
         st_in = STATUS_OK;
         if (op_ins) begin
            if (is_full) begin
               st_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else if (op_drop_last || op_drop_first) begin
            if (is_empty) begin
               st_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end else if (op_remove) begin
            if (is_empty) begin
               st_in = STATUS_EMPTY;
            end else if (found_any) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               st_in = STATUS_NOT_FOUND;
            end
         end else if (op_get) begin
            if (is_empty) begin
               st_in = STATUS_EMPTY;
            end else begin
               rd_in = entry[rd_pos];
            end
         end
      end
   end

   assign back_pos = last_pos[IDX_W-1:0];

   always_comb begin
      rsp_in = rsp_ff;
      if (busy_ff) begin
         rsp_in.read_value  = rd_ff;
         rsp_in.front_value = is_empty ? '0 : entry[0];
         rsp_in.back_value  = is_empty ? '0 : entry[back_pos];
         rsp_in.entry_count = ENTRY_COUNT_W'(count_ff);
         rsp_in.status      = st_ff;
      end
   end

   assign busy_in = accept;

   always_comb begin
      if (busy_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff  <= rd_in;
      st_ff  <= st_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/bol_checker.sv -----
// Port-level checks for bounded_ordered_list_unit, attached by bind.
// Depends on bol_pkg and the top level's port list.
`default_nettype none

module bol_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input wire bol_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input wire bol_pkg::rsp_type rsp_data
);
   import bol_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // A taken command word blocks the input for the update cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command word taken during update cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= ENTRY_COUNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.entry_count == '0) |->
         (rsp_data.front_value == '0) && (rsp_data.back_value == '0))
      else $error("empty list reports nonzero front or back");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |->
         rsp_data.entry_count == ENTRY_COUNT_W'(CAPACITY))
      else $error("full status with room left");

endmodule

bind bounded_ordered_list_unit bol_checker u_bol_checker (.*);

`default_nettype wire
